### rtl/apsph_pkg.sv
// Shared types, constants and helpers for the all-pairs shortest path engine.
// Used by apsph_cell, apsph_chain and all_pairs_shortest_path_hops.
// No dependencies.
package apsph_pkg;

  // Field widths fixed by the command interface.
  localparam int CMD_W    = 2;
  localparam int NODE_W   = 4;
  localparam int COST_W   = 16;
  localparam int DIST_W   = 20;
  localparam int HOP_W    = 4;
  localparam int CFG_W    = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Edge costs are limited to this many bits before they enter the matrix.
  localparam int COST_BITS = 16;

  // Row and count fields in the shared structures cover the largest build (64 nodes).
  localparam int ROW_FW = 6;
  localparam int CNT_FW = 7;

  localparam int MAX_NODES_DEF = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [HOP_W-1:0]  HOP_MAX  = '1;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 5'd16;

  // Register index carried by paddr[2].
  localparam logic REG_NODE_COUNT = 1'b0;

  localparam logic [63:0] COST_LIMIT = (COST_BITS >= 64) ? '1 :
                                       ((64'd1 << COST_BITS) - 64'd1);
  localparam logic [63:0] DIST_LIMIT = 64'(DIST_MAX);
  localparam logic [63:0] EDGE_LIMIT = (COST_LIMIT < DIST_LIMIT) ? COST_LIMIT : DIST_LIMIT;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_CLOSURE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_READ_RD,
    ST_READ_OUT,
    ST_PIVOT,
    ST_STREAM
  } state_t;

  // One matrix entry.
  typedef struct packed {
    logic              reach;
    logic [HOP_W-1:0]  hop;
    logic [DIST_W-1:0] pcost;
  } entry_t;

  // Row packet passed from cell to cell during closure: row i and d[i][k].
  typedef struct packed {
    logic              vld;
    logic [ROW_FW-1:0] row;
    entry_t            a;
  } pkt_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              clr_en;
    logic              load_en;
    logic              piv_en;
    logic [ROW_FW-1:0] addr;
    logic [ROW_FW-1:0] load_col;
    logic [DIST_W-1:0] load_cost;
    logic [CNT_FW-1:0] n_act;
  } cell_ctrl_t;

  // Saturate an incoming edge cost to the cost and distance limits.
  function automatic logic [DIST_W-1:0] limit_cost(input logic [COST_W-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    if (w > EDGE_LIMIT) w = EDGE_LIMIT;
    return DIST_W'(w);
  endfunction

endpackage

### rtl/apsph_cell.sv
// One column of the distance matrix with its relaxation unit.
// Depends on apsph_pkg; instantiated in a row by apsph_chain.
module apsph_cell import apsph_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int COL       = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  pkt_t       pkt_in,
  output pkt_t       pkt_out,
  output entry_t     rdata
);

  localparam int IDX_W = $clog2(MAX_NODES);

  entry_t            mem [MAX_NODES];
  entry_t            pivot;
  pkt_t              pkt_q;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_en;
  entry_t            wr_data;
  logic              col_active;
  logic              load_hit;
  logic              relax_upd;
  logic [DIST_W:0]   sum_full;
  logic [DIST_W-1:0] sum_sat;
  logic [HOP_W:0]    hop_full;
  logic [HOP_W-1:0]  hop_sat;

  // A passing row packet owns the read port; otherwise the sequencer's address does.
  assign rd_idx     = pkt_in.vld ? pkt_in.row[IDX_W-1:0] : ctrl.addr[IDX_W-1:0];
  assign col_active = CNT_FW'(COL) < ctrl.n_act;

  // Candidate path i->k->j, saturating on overflow.
  assign sum_full = {1'b0, pkt_q.a.pcost} + {1'b0, pivot.pcost};
  assign sum_sat  = sum_full[DIST_W] ? DIST_MAX : sum_full[DIST_W-1:0];
  assign hop_full = {1'b0, pkt_q.a.hop} + {1'b0, pivot.hop};
  assign hop_sat  = hop_full[HOP_W] ? HOP_MAX : hop_full[HOP_W-1:0];

  assign relax_upd = pkt_q.vld && col_active && pkt_q.a.reach && pivot.reach &&
                     (!rdata.reach || (sum_sat < rdata.pcost));

  assign load_hit = ctrl.load_en && (ctrl.load_col == ROW_FW'(COL)) &&
                    (!rdata.reach || (ctrl.load_cost < rdata.pcost));

  // Write port selection: clear sweep, then edge load, then relaxation.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = ctrl.addr[IDX_W-1:0];
    wr_data = '0;
    priority if (ctrl.clr_en) begin
      wr_en         = 1'b1;
      wr_data.reach = (ctrl.addr == ROW_FW'(COL));
    end else if (load_hit) begin
      wr_en         = 1'b1;
      wr_data.reach = 1'b1;
      wr_data.hop   = HOP_W'(1);
      wr_data.pcost = ctrl.load_cost;
    end else if (relax_upd) begin
      wr_en         = 1'b1;
      wr_idx        = pkt_q.row[IDX_W-1:0];
      wr_data.reach = 1'b1;
      wr_data.hop   = hop_sat;
      wr_data.pcost = sum_sat;
    end else begin
      wr_en = 1'b0;
    end
  end

  // Column storage with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rdata <= mem[rd_idx];
  end

  // The pivot holds d[k][j] for the current intermediate node.
  always_ff @(posedge clk) begin
    if (ctrl.piv_en) begin
      pivot <= rdata;
    end
  end

  // Row packet stage; it lines up with the read data and moves on next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_q.vld <= 1'b0;
    end else begin
      pkt_q.vld <= pkt_in.vld;
    end
    pkt_q.row <= pkt_in.row;
    pkt_q.a   <= pkt_in.a;
  end

  assign pkt_out = pkt_q;

endmodule

### rtl/apsph_chain.sv
// Row of matrix cells, one per column, linked by the closure row packets.
// Depends on apsph_pkg and apsph_cell.
module apsph_chain import apsph_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  pkt_t              pkt_head,
  input  logic [ROW_FW-1:0] sel_col,
  output entry_t            sel_data,
  output pkt_t              pkt_tail
);

  pkt_t   link [MAX_NODES+1];
  entry_t rd   [MAX_NODES];

  assign link[0]  = pkt_head;
  assign pkt_tail = link[MAX_NODES];

  // Each cell hands its row packet to the next one every cycle.
  for (genvar c = 0; c < MAX_NODES; c++) begin : g_cell
    apsph_cell #(
      .MAX_NODES (MAX_NODES),
      .COL       (c)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .pkt_in  (link[c]),
      .pkt_out (link[c+1]),
      .rdata   (rd[c])
    );
  end

  // Pick one column's read data for pair reads and the pivot column copy.
  always_comb begin
    sel_data = '0;
    for (int c = 0; c < MAX_NODES; c++) begin
      if (sel_col == ROW_FW'(c)) begin
        sel_data = rd[c];
      end
    end
  end

endmodule

### rtl/all_pairs_shortest_path_hops.sv
// Top level of the all-pairs shortest path engine with hop counts.
// Depends on apsph_pkg and apsph_chain.
//
// A command is taken when start is high and busy is low; every command gives one result,
// shown for a single cycle with done, which the receiver must take as it comes. A load or
// a read stays busy through a read state and then a write or output state, and its result
// is registered from the second; an invalid load or read answers in the cycle after the
// command without going busy. A clear sweeps one matrix row per cycle through all MAX_NODES
// rows. A closure runs, for each intermediate node k, a copy of column k followed by a pass
// of n row packets along the chain of column cells, where n is the node count in use; each
// column store has a single read and write port. After reset the matrix is cleared by the
// same sweep, and busy stays high until that sweep ends. node_count is written through the
// APB port at address 0 and must only be changed while the block is idle.
module all_pairs_shortest_path_hops import apsph_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // Command
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  command,
  input  logic [NODE_W-1:0] src_node,
  input  logic [NODE_W-1:0] dst_node,
  input  logic [COST_W-1:0] edge_cost,
  // Result
  output logic              done,
  output logic [DIST_W-1:0] path_cost,
  output logic [HOP_W-1:0]  hop_count,
  output logic              reachable
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int AW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]  node_count;
  logic [AW-1:0]     n_raw;
  logic [AW-1:0]     n_act;
  logic              in_valid;
  logic              accept;
  cmd_t              cmd_in;

  state_t            state;
  state_t            state_next;
  logic [AW-1:0]     cnt;
  logic [AW-1:0]     kk;
  logic [ROW_FW-1:0] src_q;
  logic [ROW_FW-1:0] dst_q;
  logic [DIST_W-1:0] cost_q;

  logic              prev_vld;
  logic [IDX_W-1:0]  prev_row;
  entry_t            colbuf [MAX_NODES];
  entry_t            buf_rdata;
  logic              strm_vld;
  logic [ROW_FW-1:0] strm_row;

  cell_ctrl_t        ctrl;
  logic [ROW_FW-1:0] sel_col;
  entry_t            sel_data;
  pkt_t              pkt_head;
  pkt_t              pkt_tail;

  logic              clr_last;
  logic              piv_last;
  logic              tail_done;
  logic              k_last;
  logic              cfg_wr;

  logic              fin;
  logic [DIST_W-1:0] fin_cost;
  logic [HOP_W-1:0]  fin_hop;
  logic              fin_reach;

  // Node count in use: zero acts as one, anything above the build acts as the build.
  assign n_raw = AW'(node_count);
  always_comb begin
    priority if (n_raw == '0) begin
      n_act = AW'(1);
    end else if (n_raw > AW'(MAX_NODES)) begin
      n_act = AW'(MAX_NODES);
    end else begin
      n_act = n_raw;
    end
  end

  assign cmd_in   = cmd_t'(command);
  assign accept   = start && !busy;
  assign in_valid = (AW'(src_node) < n_act) && (AW'(dst_node) < n_act);

  assign clr_last  = (cnt == AW'(MAX_NODES - 1));
  assign piv_last  = (cnt == n_act);
  assign k_last    = (kk == n_act - AW'(1));
  assign tail_done = pkt_tail.vld && (pkt_tail.row == ROW_FW'(n_act - AW'(1)));

  // APB register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DW'(node_count) : '0;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            CMD_CLEAR:   state_next = ST_CLEAR;
            CMD_LOAD:    state_next = in_valid ? ST_LOAD_RD : ST_IDLE;
            CMD_CLOSURE: state_next = ST_PIVOT;
            CMD_READ:    state_next = in_valid ? ST_READ_RD : ST_IDLE;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_LOAD_RD:  state_next = ST_LOAD_WR;
      ST_LOAD_WR:  state_next = ST_IDLE;
      ST_READ_RD:  state_next = ST_READ_OUT;
      ST_READ_OUT: state_next = ST_IDLE;
      ST_PIVOT: begin
        if (piv_last) state_next = ST_STREAM;
      end
      ST_STREAM: begin
        if (tail_done) state_next = k_last ? ST_IDLE : ST_PIVOT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell control, column select and the result to register.
  always_comb begin
    busy           = (state != ST_IDLE);
    ctrl.clr_en    = 1'b0;
    ctrl.load_en   = 1'b0;
    ctrl.piv_en    = 1'b0;
    ctrl.addr      = src_q;
    ctrl.load_col  = dst_q;
    ctrl.load_cost = cost_q;
    ctrl.n_act     = CNT_FW'(n_act);
    sel_col        = ROW_FW'(kk);
    fin            = 1'b0;
    fin_cost       = '0;
    fin_hop        = '0;
    fin_reach      = 1'b0;
    unique case (state)
      ST_INIT: begin
        ctrl.clr_en = 1'b1;
        ctrl.addr   = ROW_FW'(cnt);
      end
      ST_IDLE: begin
        // An out-of-range load or read answers at once with an empty result.
        fin = accept && !in_valid && ((cmd_in == CMD_LOAD) || (cmd_in == CMD_READ));
      end
      ST_CLEAR: begin
        ctrl.clr_en = 1'b1;
        ctrl.addr   = ROW_FW'(cnt);
        fin         = clr_last;
      end
      ST_LOAD_RD: begin
        ctrl.addr = src_q;
      end
      ST_LOAD_WR: begin
        ctrl.load_en = 1'b1;
        fin          = 1'b1;
      end
      ST_READ_RD: begin
        ctrl.addr = src_q;
      end
      ST_READ_OUT: begin
        sel_col   = dst_q;
        fin       = 1'b1;
        fin_reach = sel_data.reach;
        fin_cost  = sel_data.reach ? sel_data.pcost : '0;
        fin_hop   = sel_data.reach ? sel_data.hop : '0;
      end
      ST_PIVOT: begin
        ctrl.addr   = ROW_FW'(cnt);
        ctrl.piv_en = prev_vld && (prev_row == kk[IDX_W-1:0]);
      end
      ST_STREAM: begin
        fin = tail_done && k_last;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      kk         <= '0;
      prev_vld   <= 1'b0;
      strm_vld   <= 1'b0;
      done       <= 1'b0;
      node_count <= NODE_COUNT_RESET;
    end else begin
      state    <= state_next;
      done     <= fin;
      prev_vld <= (state == ST_PIVOT) && (cnt < n_act);
      strm_vld <= (state == ST_STREAM) && (cnt < n_act);

      unique case (state)
        ST_INIT, ST_CLEAR: cnt <= clr_last ? '0 : cnt + AW'(1);
        ST_PIVOT:          cnt <= piv_last ? '0 : cnt + AW'(1);
        ST_STREAM: begin
          if (tail_done) begin
            cnt <= '0;
          end else if (cnt < n_act) begin
            cnt <= cnt + AW'(1);
          end
        end
        default: cnt <= '0;
      endcase

      if (accept) begin
        kk <= '0;
      end else if ((state == ST_STREAM) && tail_done) begin
        kk <= kk + AW'(1);
      end

      if (cfg_wr && (paddr[2] == REG_NODE_COUNT)) begin
        node_count <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Command fields and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      src_q  <= ROW_FW'(src_node);
      dst_q  <= ROW_FW'(dst_node);
      cost_q <= limit_cost(edge_cost);
    end
    prev_row  <= cnt[IDX_W-1:0];
    strm_row  <= ROW_FW'(cnt);
    path_cost <= fin_cost;
    hop_count <= fin_hop;
    reachable <= fin_reach;
  end

  // Copy of column k, written during the pivot sweep and streamed into the chain.
  always_ff @(posedge clk) begin
    if (prev_vld) begin
      colbuf[prev_row] <= sel_data;
    end
    buf_rdata <= colbuf[cnt[IDX_W-1:0]];
  end

  assign pkt_head.vld = strm_vld;
  assign pkt_head.row = strm_row;
  assign pkt_head.a   = buf_rdata;

  apsph_chain #(
    .MAX_NODES (MAX_NODES)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .pkt_head (pkt_head),
    .sel_col  (sel_col),
    .sel_data (sel_data),
    .pkt_tail (pkt_tail)
  );

`ifndef ASSERT_OFF
  // A valid pair read answers with done once its read and output states have passed.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd_in == CMD_READ) && in_valid) |-> ##3 done)
    else $error("pair read did not answer on time");

  // Leaving the busy state always delivers a result, except after the reset sweep.
  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done || ($past(state) == ST_INIT)))
    else $error("busy fell without a result");

  // No result without a transaction in progress or just taken.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a transaction");

  // The last row packet cannot leave the chain before every row has been issued.
  a_stream_order: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_STREAM) && tail_done) |-> (cnt == n_act))
    else $error("closure pass ended before all rows were streamed");
`endif

endmodule
